// File: rtl/core/kptl_pkg.sv
package kptl_pkg;

  localparam int MAX_PAIRS = 1024;
  localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

  localparam int OP_W      = 1;
  localparam int POS_W     = 10;
  localparam int GLYPH_W   = 16;
  localparam int KERN_W    = 16;
  localparam int CFG_W     = 11;

  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [GLYPH_W-1:0]       left;
    logic [GLYPH_W-1:0]       right;
    logic signed [KERN_W-1:0] kern;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/core/kptl_req_if.sv
interface kptl_req_if import kptl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         entry_index;
  logic [GLYPH_W-1:0]       left_glyph;
  logic [GLYPH_W-1:0]       right_glyph;
  logic signed [KERN_W-1:0] kern_in;

  modport source (
    output valid, opcode, entry_index, left_glyph, right_glyph, kern_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, entry_index, left_glyph, right_glyph, kern_in,
    output ready
  );
endinterface

// File: rtl/core/kptl_rsp_if.sv
interface kptl_rsp_if import kptl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [KERN_W-1:0] kern_value;
  logic                     found;

  modport source (
    output valid, kern_value, found,
    input  ready
  );

  modport sink (
    input  valid, kern_value, found,
    output ready
  );
endinterface

// File: rtl/core/kptl_table.sv
module kptl_table import kptl_pkg::*; (
  input  logic    clk,
  input  tbl_wr_t wr,
  input  tbl_rd_t rd,
  output entry_t  rd_data
);

  entry_t mem [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: rtl/core/kern_pair_table_lookup.sv
// Kerning pair table with binary-search lookup. Write beats (opcode 0) store
// {left_glyph, right_glyph, kern_in} at entry_index and give no response; lookup
// beats (opcode 1) search the first pair_count entries, which software keeps
// sorted by left then right glyph, and return one response beat with the
// matching kern_value and found set, or zero with found clear on a miss or an
// empty table. The next beat is not taken until a lookup's search is done and
// its response loaded. A search of n entries makes at most floor(log2(n)) + 1
// probes (11 for a full table of 1024 pairs): the pair table is
// a single-read-port synchronous RAM and the search reads one entry per cycle,
// choosing the next address from the data just read. A finished response sits
// in an output register, so the next beat is taken while it waits. The table
// is not cleared at reset; pair_count resets to zero and must only cover
// entries already written. Write pair_count only while the block is idle.
module kern_pair_table_lookup import kptl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  kptl_req_if.sink         req,
  kptl_rsp_if.source       rsp
);

  state_t state, state_next;

  logic [CFG_W-1:0]   pair_count;
  logic [CNT_W-1:0]   n_clamp;
  logic [CNT_W-1:0]   lo, lo_next, hi, hi_next, mid, mid_next;
  logic [CNT_W-1:0]   lo_n, hi_n;
  logic [GLYPH_W-1:0] key_left, key_right;

  logic signed [KERN_W-1:0] res_kern, res_kern_next;
  logic                     res_found, res_found_next;
  logic                     out_valid, load_out;
  logic                     key_less, key_equal, lookup_accept;

  tbl_wr_t tbl_wr;
  tbl_rd_t tbl_rd;
  entry_t  rd_data;

  kptl_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
    end else if (cfg_wr_en) begin
      pair_count <= cfg_wr_data;
    end
  end

  assign n_clamp = (32'(pair_count) > MAX_PAIRS) ? CNT_W'(MAX_PAIRS) : CNT_W'(pair_count);

  assign lookup_accept = req.valid && req.ready && (req.opcode == OP_LOOKUP);

  assign key_equal = (rd_data.left == key_left) && (rd_data.right == key_right);
  assign key_less  = (rd_data.left < key_left) ||
                     ((rd_data.left == key_left) && (rd_data.right < key_right));

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    res_kern_next  = res_kern;
    res_found_next = res_found;
    lo_n           = lo;
    hi_n           = hi;
    req.ready      = 1'b0;
    load_out       = 1'b0;
    tbl_wr         = '0;
    tbl_rd.en      = 1'b0;
    tbl_rd.addr    = mid_next[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.opcode == OP_WRITE) begin
            tbl_wr.en         = (32'(req.entry_index) < MAX_PAIRS);
            tbl_wr.addr       = IDX_W'(req.entry_index);
            tbl_wr.data.left  = req.left_glyph;
            tbl_wr.data.right = req.right_glyph;
            tbl_wr.data.kern  = req.kern_in;
          end else begin
            lo_next        = '0;
            hi_next        = n_clamp;
            mid_next       = n_clamp >> 1;
            res_kern_next  = '0;
            res_found_next = 1'b0;
            tbl_rd.en      = (n_clamp != '0);
            tbl_rd.addr    = mid_next[IDX_W-1:0];
            state_next     = (n_clamp == '0) ? ST_FINISH : ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (key_equal) begin
          res_kern_next  = rd_data.kern;
          res_found_next = 1'b1;
          state_next     = ST_FINISH;
        end else begin
          if (key_less) begin
            lo_n = mid + CNT_W'(1);
          end else begin
            hi_n = mid;
          end
          lo_next = lo_n;
          hi_next = hi_n;
          if (lo_n >= hi_n) begin
            state_next = ST_FINISH;
          end else begin
            mid_next    = lo_n + ((hi_n - lo_n) >> 1);
            tbl_rd.en   = 1'b1;
            tbl_rd.addr = mid_next[IDX_W-1:0];
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    res_kern  <= res_kern_next;
    res_found <= res_found_next;
    if (lookup_accept) begin
      key_left  <= req.left_glyph;
      key_right <= req.right_glyph;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.kern_value <= res_kern;
      rsp.found      <= res_found;
    end
  end

  assign rsp.valid = out_valid;

`ifndef SYNTHESIS
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hi && mid >= lo && mid < hi && hi <= n_clamp))
    else $error("search probe outside the live range");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.kern_value == '0))
    else $error("miss response carries a nonzero adjustment");

  a_lookup_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    lookup_accept |=> (state == ST_SEARCH || state == ST_FINISH))
    else $error("lookup beat accepted without starting a search");

  a_one_response: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (state == ST_FINISH && (!out_valid || rsp.ready)))
    else $error("response register loaded over a pending beat");
`endif

endmodule
